@@ rtl/hlt_pkg.sv @@
// ----------------------------------------------------------------------------
// hlt_pkg
// Shared types and codes for the held lock tracker: sequencer states, result
// status codes and the command that the sequencer sends to the slot table.
// ----------------------------------------------------------------------------
package hlt_pkg;

    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 5;
    localparam int LOCK_W   = 32;

    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [SLOT_W-1:0]   slot_t;

    localparam status_t STAT_OK       = 3'd0;
    localparam status_t STAT_HELD     = 3'd1;
    localparam status_t STAT_FULL     = 3'd2;
    localparam status_t STAT_UNLOCKED = 3'd3;
    localparam status_t STAT_NOTREC   = 3'd4;

    localparam logic OP_LOCK   = 1'b0;
    localparam logic OP_UNLOCK = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } hlt_state_t;

    // table update issued when a result is handed to the output register
    typedef struct packed {
        logic  wr;
        logic  clr;
        slot_t slot;
    } hlt_tbl_cmd_t;

    // per-slot answer of the compare unit at the current scan position
    typedef struct packed {
        logic hit;
        logic free;
    } hlt_tbl_stat_t;

endpackage

@@ rtl/hlt_table.sv @@
// ----------------------------------------------------------------------------
// hlt_table
// Slot table: held addresses, per-slot valid bits and the single address
// comparator shared by every step of the scan.
// ----------------------------------------------------------------------------
module hlt_table #(
    parameter int TABLE_ENTRIES = 10,
    parameter int ADDR_WIDTH    = 32
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  hlt_pkg::slot_t          scan_slot,
    input  logic [ADDR_WIDTH-1:0]   cmp_addr,
    input  hlt_pkg::hlt_tbl_cmd_t   cmd,
    output hlt_pkg::hlt_tbl_stat_t  stat
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    logic [ADDR_WIDTH-1:0]    addr_mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [TABLE_ENTRIES-1:0] valid_next;
    logic [IDX_W-1:0]         rd_idx;
    logic [IDX_W-1:0]         wr_idx;

    assign rd_idx = scan_slot[IDX_W-1:0];
    assign wr_idx = cmd.slot[IDX_W-1:0];

    always_comb begin
        valid_next = valid_reg;
        if (cmd.wr) begin
            valid_next[wr_idx] = 1'b1;
        end
        if (cmd.clr) begin
            valid_next[wr_idx] = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // entries are only compared while valid, so no reset needed
    always_ff @(posedge aclk) begin
        if (cmd.wr) begin
            addr_mem[wr_idx] <= cmp_addr;
        end
    end

    always_comb begin
        stat.free = !valid_reg[rd_idx];
        stat.hit  = valid_reg[rd_idx] && (addr_mem[rd_idx] == cmp_addr);
    end

endmodule

@@ rtl/hlt_ctrl.sv @@
// ----------------------------------------------------------------------------
// hlt_ctrl
// Sequencer: takes one request, steps the table comparator across the slots,
// decides the status and slot, and holds the result in the output register.
// ----------------------------------------------------------------------------
module hlt_ctrl #(
    parameter int TABLE_ENTRIES = 10,
    parameter int ADDR_WIDTH    = 32
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_op,
    input  logic [31:0]             s_lock_address,
    input  logic                    s_lock_word_zero,
    output logic                    m_valid,
    input  logic                    m_ready,
    output hlt_pkg::status_t        m_status,
    output hlt_pkg::slot_t          m_slot,
    output hlt_pkg::slot_t          scan_slot,
    output logic [ADDR_WIDTH-1:0]   cmp_addr,
    output hlt_pkg::hlt_tbl_cmd_t   cmd,
    input  hlt_pkg::hlt_tbl_stat_t  stat
);

    localparam int KEEP_W = (ADDR_WIDTH < hlt_pkg::LOCK_W) ? ADDR_WIDTH : hlt_pkg::LOCK_W;
    localparam hlt_pkg::slot_t LAST_SLOT = hlt_pkg::SLOT_W'(TABLE_ENTRIES - 1);

    hlt_pkg::hlt_state_t   state_reg, state_next;
    logic                  op_reg, op_next;
    logic [ADDR_WIDTH-1:0] addr_reg, addr_next;
    hlt_pkg::slot_t        idx_reg, idx_next;
    logic                  free_found_reg, free_found_next;
    hlt_pkg::slot_t        free_slot_reg, free_slot_next;
    hlt_pkg::status_t      res_status_reg, res_status_next;
    hlt_pkg::slot_t        res_slot_reg, res_slot_next;
    logic                  res_wr_reg, res_wr_next;
    logic                  res_clr_reg, res_clr_next;
    logic                  m_valid_reg, m_valid_next;
    hlt_pkg::status_t      m_status_reg, m_status_next;
    hlt_pkg::slot_t        m_slot_reg, m_slot_next;

    logic accept;
    logic scan_stop;
    logic load_out;

    assign accept    = s_valid && (state_reg == hlt_pkg::ST_IDLE);
    assign load_out  = (state_reg == hlt_pkg::ST_FINISH) && (!m_valid_reg || m_ready);
    // the scan stops at the first match or after the last slot
    assign scan_stop = stat.hit || (idx_reg == LAST_SLOT);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            hlt_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if ((s_op == hlt_pkg::OP_UNLOCK) && s_lock_word_zero) begin
                        state_next = hlt_pkg::ST_FINISH;
                    end else begin
                        state_next = hlt_pkg::ST_SCAN;
                    end
                end
            end
            hlt_pkg::ST_SCAN: begin
                if (scan_stop) begin
                    state_next = hlt_pkg::ST_FINISH;
                end
            end
            hlt_pkg::ST_FINISH: begin
                if (load_out) begin
                    state_next = hlt_pkg::ST_IDLE;
                end
            end
            default: state_next = hlt_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        op_next         = op_reg;
        addr_next       = addr_reg;
        idx_next        = idx_reg;
        free_found_next = free_found_reg;
        free_slot_next  = free_slot_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_wr_next     = res_wr_reg;
        res_clr_next    = res_clr_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_slot_next     = m_slot_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            hlt_pkg::ST_IDLE: begin
                if (accept) begin
                    op_next         = s_op;
                    addr_next       = ADDR_WIDTH'(s_lock_address[KEEP_W-1:0]);
                    idx_next        = '0;
                    free_found_next = 1'b0;
                    free_slot_next  = '0;
                    res_status_next = hlt_pkg::STAT_UNLOCKED;
                    res_slot_next   = '0;
                    res_wr_next     = 1'b0;
                    res_clr_next    = 1'b0;
                end
            end
            hlt_pkg::ST_SCAN: begin
                if (stat.free && !free_found_reg) begin
                    free_found_next = 1'b1;
                    free_slot_next  = idx_reg;
                end
                if (stat.hit) begin
                    if (op_reg == hlt_pkg::OP_LOCK) begin
                        res_status_next = hlt_pkg::STAT_HELD;
                        res_slot_next   = '0;
                    end else begin
                        res_status_next = hlt_pkg::STAT_OK;
                        res_slot_next   = idx_reg;
                        res_clr_next    = 1'b1;
                    end
                end else if (idx_reg == LAST_SLOT) begin
                    if (op_reg == hlt_pkg::OP_UNLOCK) begin
                        res_status_next = hlt_pkg::STAT_NOTREC;
                        res_slot_next   = '0;
                    end else if (free_found_reg) begin
                        res_status_next = hlt_pkg::STAT_OK;
                        res_slot_next   = free_slot_reg;
                        res_wr_next     = 1'b1;
                    end else if (stat.free) begin
                        res_status_next = hlt_pkg::STAT_OK;
                        res_slot_next   = idx_reg;
                        res_wr_next     = 1'b1;
                    end else begin
                        res_status_next = hlt_pkg::STAT_FULL;
                        res_slot_next   = '0;
                    end
                end else begin
                    idx_next = idx_reg + hlt_pkg::SLOT_W'(1);
                end
            end
            hlt_pkg::ST_FINISH: begin
                if (load_out) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_slot_next   = res_slot_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= hlt_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        addr_reg       <= addr_next;
        idx_reg        <= idx_next;
        free_found_reg <= free_found_next;
        free_slot_reg  <= free_slot_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_wr_reg     <= res_wr_next;
        res_clr_reg    <= res_clr_next;
        m_status_reg   <= m_status_next;
        m_slot_reg     <= m_slot_next;
    end

    // table changes land together with the result transfer into the output
    always_comb begin
        cmd.wr   = load_out && res_wr_reg;
        cmd.clr  = load_out && res_clr_reg;
        cmd.slot = res_slot_reg;
    end

    assign s_ready   = (state_reg == hlt_pkg::ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_status  = m_status_reg;
    assign m_slot    = m_slot_reg;
    assign scan_slot = idx_reg;
    assign cmp_addr  = addr_reg;

endmodule

@@ rtl/held_lock_tracker.sv @@
// ----------------------------------------------------------------------------
// held_lock_tracker
// Records which lock addresses are held. Lock requests add an address to the
// lowest free slot unless already present; unlock requests free the match.
// ----------------------------------------------------------------------------
//  channel | ports                                        | direction
//  --------+----------------------------------------------+----------
//  request | s_valid s_ready s_op s_lock_address          | in
//          | s_lock_word_zero                             |
//  result  | m_valid m_ready m_status m_slot              | out
//
//  one request at a time; the slot comparator walks the table one slot a cycle
//  the scan stops at the first match or after the last slot; an unlock with
//  a zero lock word skips the scan and goes straight to the result
//  a new request is taken while an earlier result still waits on m_ready; its
//  own result then holds the sequencer until the output register drains
//  reset clears the valid bits only; no clearing pass
// ----------------------------------------------------------------------------
module held_lock_tracker #(
    parameter int TABLE_ENTRIES = 10,
    parameter int ADDR_WIDTH    = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_op,
    input  logic [31:0]      s_lock_address,
    input  logic             s_lock_word_zero,
    output logic             m_valid,
    input  logic             m_ready,
    output hlt_pkg::status_t m_status,
    output hlt_pkg::slot_t   m_slot
);

    hlt_pkg::slot_t         scan_slot;
    logic [ADDR_WIDTH-1:0]  cmp_addr;
    hlt_pkg::hlt_tbl_cmd_t  tbl_cmd;
    hlt_pkg::hlt_tbl_stat_t tbl_stat;

    hlt_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .ADDR_WIDTH    (ADDR_WIDTH)
    ) u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_op             (s_op),
        .s_lock_address   (s_lock_address),
        .s_lock_word_zero (s_lock_word_zero),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_slot           (m_slot),
        .scan_slot        (scan_slot),
        .cmp_addr         (cmp_addr),
        .cmd              (tbl_cmd),
        .stat             (tbl_stat)
    );

    hlt_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .ADDR_WIDTH    (ADDR_WIDTH)
    ) u_table (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .scan_slot (scan_slot),
        .cmp_addr  (cmp_addr),
        .cmd       (tbl_cmd),
        .stat      (tbl_stat)
    );

endmodule

@@ rtl/hlt_checker.sv @@
// ----------------------------------------------------------------------------
// hlt_checker
// Port-level checks for the held lock tracker, bound to the top level.
// ----------------------------------------------------------------------------
module hlt_checker #(
    parameter int TABLE_ENTRIES = 10
) (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input hlt_pkg::status_t m_status,
    input hlt_pkg::slot_t   m_slot
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_slot))
        else $error("result changed while stalled");

    // only one request in work at a time
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while busy");

    a_err_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != hlt_pkg::STAT_OK) |-> (m_slot == '0))
        else $error("error result with nonzero slot");

    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == hlt_pkg::STAT_OK)
            |-> (32'(m_slot) < 32'(TABLE_ENTRIES)))
        else $error("slot beyond table");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == hlt_pkg::STAT_OK) || (m_status == hlt_pkg::STAT_HELD)
            || (m_status == hlt_pkg::STAT_FULL) || (m_status == hlt_pkg::STAT_UNLOCKED)
            || (m_status == hlt_pkg::STAT_NOTREC))
        else $error("undefined status code");

endmodule

bind held_lock_tracker hlt_checker #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
) u_hlt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_status (m_status),
    .m_slot   (m_slot)
);

@@ sim/tb_held_lock_tracker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_held_lock_tracker
// Self-checking bench for the held lock tracker. Lock and unlock requests go
// through the request channel. A scoreboard keeps its own copy of the slot
// table and predicts each result, then compares it with what comes back on the
// result channel. A short directed list comes first, then random traffic under
// three flow-control phases and one long result stall.
// ----------------------------------------------------------------------------
module tb_held_lock_tracker;

    localparam int NUM_SLOTS    = 10;
    localparam int RAND_ITEMS   = 1300;
    localparam int QUIET_LIMIT  = 1000;
    localparam int STALL_CYCLES = 150;
    localparam int POOL_SIZE    = 12;

    typedef struct {
        hlt_pkg::status_t status;
        hlt_pkg::slot_t   slot;
    } lock_result_t;

    // ------------------------------------------------------------------------
    // slot table model and result queue
    // ------------------------------------------------------------------------
    class lock_table_sb;
        logic [31:0]          held_addr [NUM_SLOTS];
        logic [NUM_SLOTS-1:0] held_valid;
        lock_result_t         expected_q [$];
        int                   errors;
        int                   checked;
        int                   status_seen [5];

        function new();
            held_valid = '0;
            errors     = 0;
            checked    = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        // lowest valid slot holding addr, or -1
        function int find_held(logic [31:0] addr);
            for (int s = 0; s < NUM_SLOTS; s++)
                if (held_valid[s] && held_addr[s] == addr)
                    return s;
            return -1;
        endfunction

        function int held_count();
            return $countones(held_valid);
        endfunction

        // address of a random occupied slot; caller makes sure one exists
        function logic [31:0] pick_held();
            int n;
            n = $urandom_range(held_count() - 1);
            for (int s = 0; s < NUM_SLOTS; s++) begin
                if (held_valid[s]) begin
                    if (n == 0)
                        return held_addr[s];
                    n--;
                end
            end
            return '0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_request(logic op, logic [31:0] addr, logic word_zero);
            lock_result_t r;
            int           hit;
            int           free_slot;
            r.status = hlt_pkg::STAT_OK;
            r.slot   = '0;
            if (op == hlt_pkg::OP_LOCK) begin
                hit = find_held(addr);
                if (hit >= 0) begin
                    r.status = hlt_pkg::STAT_HELD;
                end else begin
                    free_slot = -1;
                    for (int s = NUM_SLOTS - 1; s >= 0; s--)
                        if (!held_valid[s])
                            free_slot = s;
                    if (free_slot < 0) begin
                        r.status = hlt_pkg::STAT_FULL;
                    end else begin
                        held_addr[free_slot]  = addr;
                        held_valid[free_slot] = 1'b1;
                        r.slot = hlt_pkg::slot_t'(free_slot);
                    end
                end
            end else if (word_zero) begin
                // lock word check comes before any table search
                r.status = hlt_pkg::STAT_UNLOCKED;
            end else begin
                hit = find_held(addr);
                if (hit < 0) begin
                    r.status = hlt_pkg::STAT_NOTREC;
                end else begin
                    held_valid[hit] = 1'b0;
                    held_addr[hit]  = '0;
                    r.slot = hlt_pkg::slot_t'(hit);
                end
            end
            expected_q.push_back(r);
        endfunction

        function void check_result(hlt_pkg::status_t status, hlt_pkg::slot_t slot);
            lock_result_t r;
            if (expected_q.size() == 0) begin
                $error("result with no request waiting: status %0d slot %0d", status, slot);
                errors++;
                return;
            end
            r = expected_q.pop_front();
            checked++;
            if (status != r.status) begin
                $error("status mismatch: expected %0d, actual %0d", r.status, status);
                errors++;
            end
            if (slot != r.slot) begin
                $error("slot mismatch: expected %0d, actual %0d", r.slot, slot);
                errors++;
            end
            if (status <= hlt_pkg::STAT_NOTREC)
                status_seen[status]++;
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and block
    // ------------------------------------------------------------------------
    logic             aclk;
    logic             aresetn          = 1'b0;
    logic             s_valid          = 1'b0;
    logic             s_ready;
    logic             s_op             = hlt_pkg::OP_LOCK;
    logic    [31:0]   s_lock_address   = '0;
    logic             s_lock_word_zero = 1'b0;
    logic             m_valid;
    logic             m_ready          = 1'b0;
    hlt_pkg::status_t m_status;
    hlt_pkg::slot_t   m_slot;

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    held_lock_tracker #(
        .TABLE_ENTRIES (NUM_SLOTS),
        .ADDR_WIDTH    (32)
    ) dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_op             (s_op),
        .s_lock_address   (s_lock_address),
        .s_lock_word_zero (s_lock_word_zero),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_slot           (m_slot)
    );

    lock_table_sb sb;
    int           tx_idle_pct = 0;
    int           rx_idle_pct = 0;
    logic         hold_go     = 1'b0;
    int           sent        = 0;
    logic [31:0]  addr_pool [POOL_SIZE];

    // ------------------------------------------------------------------------
    // result side: random ready, one long hold-off on request
    // ------------------------------------------------------------------------
    int   hold_left  = 0;
    logic hold_taken = 1'b0;

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_status, m_slot);
        if (hold_go && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = STALL_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= aresetn && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: cycles with no transfer on either channel
    // ------------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                         quiet_cycles, sb.pending());
                $display("** held_lock_tracker: FAILED **");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------------
    task automatic send_request(input logic op, input logic [31:0] addr,
                                input logic word_zero);
        int gap;
        if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
            gap = $urandom_range(4, 1);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_op             <= op;
        s_lock_address   <= addr;
        s_lock_word_zero <= word_zero;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(op, addr, word_zero);
        sent++;
    endtask

    task automatic run_directed();
        logic [31:0] fill [8];
        fill = '{32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0000, 32'h0000_0001,
                 32'h1234_5678, 32'hFFFF_FFFE, 32'h7FFF_FFFF, 32'hDEAD_BEEF};
        send_request(hlt_pkg::OP_LOCK,   32'h0000_0000, 1'b0);  // zero is an ordinary address
        send_request(hlt_pkg::OP_LOCK,   32'hFFFF_FFFF, 1'b0);
        send_request(hlt_pkg::OP_LOCK,   32'h0000_0000, 1'b1);  // duplicate, word flag ignored
        send_request(hlt_pkg::OP_UNLOCK, 32'h0000_0000, 1'b1);  // already unlocked wins
        send_request(hlt_pkg::OP_UNLOCK, 32'h0F0F_0F0F, 1'b0);  // never recorded
        foreach (fill[k])
            send_request(hlt_pkg::OP_LOCK, fill[k], k[0]);
        send_request(hlt_pkg::OP_LOCK,   32'h0BAD_CAFE, 1'b0);  // table full
        send_request(hlt_pkg::OP_UNLOCK, 32'hFFFF_FFFF, 1'b0);
        send_request(hlt_pkg::OP_LOCK,   32'h0BAD_CAFE, 1'b0);  // reuses the freed slot
        send_request(hlt_pkg::OP_UNLOCK, 32'h5555_5555, 1'b0);
        send_request(hlt_pkg::OP_UNLOCK, 32'h0000_0000, 1'b0);
        send_request(hlt_pkg::OP_UNLOCK, 32'h0000_0000, 1'b0);  // gone now
    endtask

    // lock mostly from a small pool so duplicates and a full table happen;
    // unlock mostly what is held
    task automatic run_random(input int count, input int phase);
        int          lock_pct;
        logic        op;
        logic [31:0] addr;
        logic        word_zero;
        lock_pct = 70;
        for (int i = 0; i < count; i++) begin
            if (i % 64 == 63)
                lock_pct = (lock_pct == 70) ? 30 : 70;
            if (i % 50 == 49)
                addr_pool[$urandom_range(POOL_SIZE - 1)] = $urandom;
            if (phase == 2 && i == 20)
                hold_go <= 1'b1;
            op        = ($urandom_range(99) < lock_pct) ? hlt_pkg::OP_LOCK : hlt_pkg::OP_UNLOCK;
            word_zero = 1'($urandom_range(1));
            if (op == hlt_pkg::OP_LOCK) begin
                addr = ($urandom_range(99) < 75) ? addr_pool[$urandom_range(POOL_SIZE - 1)]
                                                 : $urandom;
            end else begin
                word_zero = ($urandom_range(99) < 15);
                if (sb.held_count() > 0 && $urandom_range(99) < 65)
                    addr = sb.pick_held();
                else if ($urandom_range(99) < 60)
                    addr = addr_pool[$urandom_range(POOL_SIZE - 1)];
                else
                    addr = $urandom;
            end
            send_request(op, addr, word_zero);
        end
    endtask

    initial begin
        sb = new();
        addr_pool[0] = 32'h0000_0000;
        addr_pool[1] = 32'hFFFF_FFFF;
        for (int p = 2; p < POOL_SIZE; p++)
            addr_pool[p] = $urandom;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        tx_idle_pct = 15;
        rx_idle_pct <= 52;
        run_directed();
        run_random(RAND_ITEMS / 3, 0);

        tx_idle_pct = 52;
        rx_idle_pct <= 15;
        run_random(RAND_ITEMS / 3, 1);

        // no idling; the long result stall is started from here
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        run_random(RAND_ITEMS - 2 * (RAND_ITEMS / 3), 2);

        @(posedge aclk);
        s_valid <= 1'b0;
        while (sb.pending() > 0) @(posedge aclk);
        repeat (NUM_SLOTS + 6) @(posedge aclk);

        $display("run covered %0d requests and %0d checked results", sent, sb.checked);
        $display("status mix: ok %0d, held %0d, full %0d, unlocked %0d, not recorded %0d",
                 sb.status_seen[hlt_pkg::STAT_OK], sb.status_seen[hlt_pkg::STAT_HELD],
                 sb.status_seen[hlt_pkg::STAT_FULL], sb.status_seen[hlt_pkg::STAT_UNLOCKED],
                 sb.status_seen[hlt_pkg::STAT_NOTREC]);
        if (sb.errors == 0) begin
            $display("** held_lock_tracker: PASSED **");
        end else begin
            $display("** held_lock_tracker: FAILED **");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/hlt_pkg.sv
rtl/hlt_table.sv
rtl/hlt_ctrl.sv
rtl/held_lock_tracker.sv
rtl/hlt_checker.sv
sim/tb_held_lock_tracker.sv
